[src/sphere_collision_test_assert.svh]
// Assertion macros for the sphere collision test RTL.
`ifndef SPHERE_COLLISION_TEST_ASSERT_SVH
`define SPHERE_COLLISION_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sct check failed");
// Next-cycle implication, checked outside reset.
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sct check failed");
`else
`define SCT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/sct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;
    // Coordinate width and derived datapath widths.
    localparam int CW   = 32;
    localparam int RADW = CW - 1;
    localparam int DW   = CW + 1;
    localparam int SW   = 2 * DW;
    localparam int RTW  = DW;
    localparam int REMW = DW + 2;
    localparam int DRW  = DW + 1;
    localparam int QW   = 31;
    localparam int GAPW = 32;
    localparam int RSW  = CW;
    localparam int GFW  = DW + 2;

    // Operation codes.
    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    // Per-item side data carried down the pipeline.
    typedef struct packed {
        logic                  op;
        logic                  hit;
        logic                  dvalid;
        logic [GAPW-1:0]       gap;
        logic [2:0]            neg;
        logic [2:0][DW-1:0]    mag;
        logic [RSW-1:0]        rsum;
    } sct_tag_t;
endpackage
`default_nettype wire

[src/sct_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module sct_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    op,
    input  wire logic [2:0][sct_pkg::CW-1:0] self_c,
    input  wire logic [sct_pkg::RADW-1:0]    self_radius,
    input  wire logic [2:0][sct_pkg::CW-1:0] other_c,
    input  wire logic [2:0][sct_pkg::CW-1:0] box_max,
    input  wire logic [sct_pkg::RADW-1:0]    other_radius,
    output logic                         out_valid,
    output sct_pkg::sct_tag_t            out_tag,
    output logic [sct_pkg::SW-1:0]       out_sum
);
    logic                          v1_reg, v2_reg, v3_reg;
    sct_pkg::sct_tag_t             t1_reg, t2_reg, t3_reg;
    sct_pkg::sct_tag_t             t1_next, t3_next;
    logic                          inv1_reg, inv2_reg;
    logic                          inv_next;
    logic [sct_pkg::RADW-1:0]      r1_reg;
    logic [2:0][sct_pkg::SW-1:0]   sq_reg;
    logic [2*sct_pkg::RADW-1:0]    r1sq_reg;
    logic [sct_pkg::SW-1:0]        sum_reg;

    // Per-axis deltas: clamp distance for the box, center difference for spheres.
    always_comb
    begin
        logic signed [sct_pkg::DW-1:0] c, o, m, dif, dbox;
        t1_next = '0;
        inv_next = 1'b0;
        t1_next.op = op;
        t1_next.rsum = {1'b0, self_radius} + {1'b0, other_radius};
        for (int k = 0; k < 3; k++)
        begin
            c = {self_c[k][sct_pkg::CW-1], self_c[k]};
            o = {other_c[k][sct_pkg::CW-1], other_c[k]};
            m = {box_max[k][sct_pkg::CW-1], box_max[k]};
            if (o > m)
            begin
                inv_next = 1'b1;
            end
            if (c < o)
            begin
                dbox = o - c;
            end
            else if (c > m)
            begin
                dbox = c - m;
            end
            else
            begin
                dbox = '0;
            end
            dif = c - o;
            if (op == sct_pkg::OP_SPHERE)
            begin
                t1_next.neg[k] = dif[sct_pkg::DW-1];
                t1_next.mag[k] = dif[sct_pkg::DW-1] ? sct_pkg::DW'(-dif) : sct_pkg::DW'(dif);
            end
            else
            begin
                t1_next.mag[k] = sct_pkg::DW'(dbox);
            end
        end
    end

    // Box hit from the summed squares against the squared radius.
    always_comb
    begin
        t3_next = t2_reg;
        t3_next.hit = !inv2_reg &&
            ((sq_reg[0] + sq_reg[1] + sq_reg[2]) < sct_pkg::SW'(r1sq_reg));
    end

    // Valid bits of the three front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 deltas, stage 2 squares, stage 3 sum and box compare.
    always_ff @(posedge clk)
    begin
        t1_reg   <= t1_next;
        inv1_reg <= inv_next;
        r1_reg   <= self_radius;
        t2_reg   <= t1_reg;
        inv2_reg <= inv1_reg;
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= t1_reg.mag[k] * t1_reg.mag[k];
        end
        r1sq_reg <= r1_reg * r1_reg;
        sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        t3_reg   <= t3_next;
    end

    assign out_valid = v3_reg;
    assign out_tag   = t3_reg;
    assign out_sum   = sum_reg;
endmodule
`default_nettype wire

[src/sct_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module sct_sqrt (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire sct_pkg::sct_tag_t     in_tag,
    input  wire logic [sct_pkg::SW-1:0] in_sum,
    output logic                       out_valid,
    output sct_pkg::sct_tag_t          out_tag,
    output logic [sct_pkg::RTW-1:0]    out_root
);
    localparam int N = sct_pkg::RTW;

    logic                          v_reg    [1:N];
    sct_pkg::sct_tag_t             tag_reg  [1:N];
    logic [sct_pkg::SW-1:0]        rad_reg  [1:N];
    logic [sct_pkg::REMW-1:0]      rem_reg  [1:N];
    logic [sct_pkg::RTW-1:0]       root_reg [1:N];

    // One root digit per stage, two radicand bits consumed each time.
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic                       v_src;
        sct_pkg::sct_tag_t          tag_src;
        logic [sct_pkg::SW-1:0]     rad_src;
        logic [sct_pkg::REMW-1:0]   rem_src;
        logic [sct_pkg::RTW-1:0]    root_src;
        logic [sct_pkg::REMW+1:0]   remx, trial;
        logic                       ge;

        if (k == 0)
        begin : g_in
            assign v_src    = in_valid;
            assign tag_src  = in_tag;
            assign rad_src  = in_sum;
            assign rem_src  = '0;
            assign root_src = '0;
        end
        else
        begin : g_mid
            assign v_src    = v_reg[k];
            assign tag_src  = tag_reg[k];
            assign rad_src  = rad_reg[k];
            assign rem_src  = rem_reg[k];
            assign root_src = root_reg[k];
        end

        assign remx  = {rem_src, rad_src[sct_pkg::SW-1 -: 2]};
        assign trial = {1'b0, root_src, 2'b01};
        assign ge    = remx >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k+1]  <= tag_src;
            rad_reg[k+1]  <= {rad_src[sct_pkg::SW-3:0], 2'b00};
            rem_reg[k+1]  <= ge ? sct_pkg::REMW'(remx - trial) : sct_pkg::REMW'(remx);
            root_reg[k+1] <= {root_src[sct_pkg::RTW-2:0], ge};
        end
    end

    assign out_valid = v_reg[N];
    assign out_tag   = tag_reg[N];
    assign out_root  = root_reg[N];
endmodule
`default_nettype wire

[src/sct_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module sct_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire sct_pkg::sct_tag_t      in_tag,
    input  wire logic [sct_pkg::RTW-1:0] in_len,
    output logic                        out_valid,
    output sct_pkg::sct_tag_t           out_tag,
    output logic [2:0][sct_pkg::QW-1:0] out_q
);
    localparam int N = sct_pkg::QW;

    logic                          v_reg   [1:N];
    sct_pkg::sct_tag_t             tag_reg [1:N];
    logic [sct_pkg::RTW-1:0]       len_reg [1:N];
    logic [2:0][sct_pkg::DRW-1:0]  rem_reg [1:N];
    logic [2:0][sct_pkg::QW-1:0]   q_reg   [1:N];

    // Restoring division, one quotient bit per stage in three lanes.
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic                          v_src;
        sct_pkg::sct_tag_t             tag_src;
        logic [sct_pkg::RTW-1:0]       len_src;
        logic [2:0][sct_pkg::DRW-1:0]  rem_src;
        logic [2:0][sct_pkg::QW-1:0]   q_src;
        logic [2:0][sct_pkg::DRW-1:0]  t, rem_nx;
        logic [2:0]                    ge;

        if (k == 0)
        begin : g_in
            assign v_src   = in_valid;
            assign tag_src = in_tag;
            assign len_src = in_len;
            assign q_src   = '0;
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_src[l] = {1'b0, in_tag.mag[l]};
                assign t[l]       = rem_src[l];
            end
        end
        else
        begin : g_mid
            assign v_src   = v_reg[k];
            assign tag_src = tag_reg[k];
            assign len_src = len_reg[k];
            assign q_src   = q_reg[k];
            assign rem_src = rem_reg[k];
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign t[l] = {rem_src[l][sct_pkg::DRW-2:0], 1'b0};
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_cmp
            assign ge[l]     = t[l] >= {1'b0, len_src};
            assign rem_nx[l] = ge[l] ? t[l] - {1'b0, len_src} : t[l];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k+1] <= tag_src;
            len_reg[k+1] <= len_src;
            rem_reg[k+1] <= rem_nx;
            for (int l = 0; l < 3; l++)
            begin
                q_reg[k+1][l] <= {q_src[l][sct_pkg::QW-2:0], ge[l]};
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_tag   = tag_reg[N];
    assign out_q     = q_reg[N];
endmodule
`default_nettype wire

[src/sphere_collision_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake        Accepted when
// query     start / busy     start high and busy low at a rising edge
// result    done             done high at a rising edge, one cycle per word
//
// One query word enters every cycle; busy is always low.
// The pipeline has 3 front stages (deltas, squares, sum), 33 square
// root stages (one root bit each), 1 gap stage, 31 divider stages and the
// output register. Reset clears only the valid bits along the pipeline.
// The receiver cannot stall, so results leave as they arrive.
`include "sphere_collision_test_assert.svh"
module sphere_collision_test (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      op,
    input  wire logic signed [31:0]        self_x,
    input  wire logic signed [31:0]        self_y,
    input  wire logic signed [31:0]        self_z,
    input  wire logic [30:0]               self_radius,
    input  wire logic signed [31:0]        other_x,
    input  wire logic signed [31:0]        other_y,
    input  wire logic signed [31:0]        other_z,
    input  wire logic signed [31:0]        box_max_x,
    input  wire logic signed [31:0]        box_max_y,
    input  wire logic signed [31:0]        box_max_z,
    input  wire logic [30:0]               other_radius,
    output logic                           done,
    output logic                           hit,
    output logic signed [31:0]             gap,
    output logic signed [31:0]             dir_x,
    output logic signed [31:0]             dir_y,
    output logic signed [31:0]             dir_z,
    output logic                           dir_valid
);
    localparam logic signed [sct_pkg::GFW-1:0] GAP_MAX = sct_pkg::GFW'(32'h7fff_ffff);
    localparam logic signed [sct_pkg::GFW-1:0] GAP_MIN = -GAP_MAX - 1;

    logic                          fv, sv, dv;
    sct_pkg::sct_tag_t             ftag, stag, dtag, gtag_next;
    logic [sct_pkg::SW-1:0]        fsum;
    logic [sct_pkg::RTW-1:0]       root;
    logic [2:0][sct_pkg::QW-1:0]   q;
    logic                          g_valid_reg;
    sct_pkg::sct_tag_t             g_tag_reg;
    logic [sct_pkg::RTW-1:0]       g_len_reg;
    logic                          done_reg;
    logic                          hit_reg, dval_reg;
    logic [sct_pkg::GAPW-1:0]      gap_reg;
    logic [2:0][31:0]              dir_reg, dir_next;

    assign busy = 1'b0;

    sct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .op           (op),
        .self_c       ({self_z, self_y, self_x}),
        .self_radius  (self_radius),
        .other_c      ({other_z, other_y, other_x}),
        .box_max      ({box_max_z, box_max_y, box_max_x}),
        .other_radius (other_radius),
        .out_valid    (fv),
        .out_tag      (ftag),
        .out_sum      (fsum)
    );

    sct_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv),
        .in_tag    (ftag),
        .in_sum    (fsum),
        .out_valid (sv),
        .out_tag   (stag),
        .out_root  (root)
    );

    // Gap, sphere hit and saturation once the center distance is known.
    always_comb
    begin
        logic signed [sct_pkg::GFW-1:0] gfull;
        gtag_next = stag;
        gfull = $signed({2'b00, root}) - $signed({3'b000, stag.rsum});
        if (stag.op == sct_pkg::OP_SPHERE)
        begin
            gtag_next.hit    = gfull[sct_pkg::GFW-1];
            gtag_next.dvalid = root != '0;
            if (gfull > GAP_MAX)
            begin
                gtag_next.gap = GAP_MAX[sct_pkg::GAPW-1:0];
            end
            else if (gfull < GAP_MIN)
            begin
                gtag_next.gap = GAP_MIN[sct_pkg::GAPW-1:0];
            end
            else
            begin
                gtag_next.gap = gfull[sct_pkg::GAPW-1:0];
            end
        end
        else
        begin
            gtag_next.dvalid = 1'b0;
            gtag_next.gap    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            g_valid_reg <= sv;
            done_reg    <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        g_tag_reg <= gtag_next;
        g_len_reg <= root;
    end

    sct_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid_reg),
        .in_tag    (g_tag_reg),
        .in_len    (g_len_reg),
        .out_valid (dv),
        .out_tag   (dtag),
        .out_q     (q)
    );

    // Signed direction components, zero when the direction is undefined.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!dtag.dvalid)
            begin
                dir_next[k] = '0;
            end
            else if (dtag.neg[k])
            begin
                dir_next[k] = -{1'b0, q[k]};
            end
            else
            begin
                dir_next[k] = {1'b0, q[k]};
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        hit_reg  <= dtag.hit;
        gap_reg  <= dtag.gap;
        dval_reg <= dtag.dvalid;
        dir_reg  <= dir_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign gap       = gap_reg;
    assign dir_x     = dir_reg[0];
    assign dir_y     = dir_reg[1];
    assign dir_z     = dir_reg[2];
    assign dir_valid = dval_reg;

    `SCT_ASSERT_NOW(a_dir_zero, clk, rst_n, done && !dir_valid, dir_x == 0 && dir_y == 0 && dir_z == 0)
    `SCT_ASSERT_NOW(a_dir_nonzero, clk, rst_n, done && dir_valid, dir_x != 0 || dir_y != 0 || dir_z != 0)
    `SCT_ASSERT_NOW(a_hit_gap, clk, rst_n, done && dir_valid, hit == gap[31])
    `SCT_ASSERT_NOW(a_box_gap, clk, rst_n, g_valid_reg && g_tag_reg.op == sct_pkg::OP_BOX, g_tag_reg.gap == '0 && !g_tag_reg.dvalid)
endmodule
`default_nettype wire

[dv/sphere_collision_test_tb.sv]
`timescale 1ns / 1ps
module sphere_collision_test_tb;
    typedef struct {
        logic               op;
        logic signed [31:0] sx, sy, sz;
        logic [30:0]        sr;
        logic signed [31:0] ox, oy, oz;
        logic signed [31:0] mx, my, mz;
        logic [30:0]        orad;
    } query_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] gap;
        logic signed [31:0] dx, dy, dz;
        logic               dvalid;
    } answer_t;

    typedef struct {
        query_t  q;
        bit      typed;
        answer_t a;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               op;
    logic signed [31:0] self_x, self_y, self_z;
    logic [30:0]        self_radius;
    logic signed [31:0] other_x, other_y, other_z;
    logic signed [31:0] box_max_x, box_max_y, box_max_z;
    logic [30:0]        other_radius;
    logic               done;
    logic               hit;
    logic signed [31:0] gap;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic               dir_valid;

    answer_t pending_answers[$];
    int      errors = 0;
    row_t    rows[$];

    sphere_collision_test DUT (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    function automatic query_t mk(logic o, int sx, int sy, int sz, int sr,
                                  int ox, int oy, int oz, int mx, int my, int mz,
                                  int orad);
        query_t q;
        q.op = o; q.sx = sx; q.sy = sy; q.sz = sz; q.sr = sr[30:0];
        q.ox = ox; q.oy = oy; q.oz = oz; q.mx = mx; q.my = my; q.mz = mz;
        q.orad = orad[30:0];
        return q;
    endfunction

    function automatic answer_t ans(logic h, int g, int dx, int dy, int dz, logic v);
        answer_t a;
        a.hit = h; a.gap = g; a.dx = dx; a.dy = dy; a.dz = dz; a.dvalid = v;
        return a;
    endfunction

    // Exact collision answer for one query word.
    function automatic answer_t collide(query_t q);
        answer_t      a;
        longint       c[3], o[3], m[3], d[3], cl, lenv, g;
        logic [127:0] sq, cand, mag, len;
        bit           bad;
        a = ans(1'b0, 0, 0, 0, 0, 1'b0);
        c[0] = longint'(q.sx); c[1] = longint'(q.sy); c[2] = longint'(q.sz);
        o[0] = longint'(q.ox); o[1] = longint'(q.oy); o[2] = longint'(q.oz);
        m[0] = longint'(q.mx); m[1] = longint'(q.my); m[2] = longint'(q.mz);
        sq = 0;
        bad = 0;
        if (q.op == sct_pkg::OP_BOX)
        begin
            // Clamp the center into the box and sum the squared distances.
            for (int k = 0; k < 3; k++)
            begin
                if (o[k] > m[k])
                    bad = 1;
                cl = c[k] < o[k] ? o[k] : (c[k] > m[k] ? m[k] : c[k]);
                mag = (c[k] >= cl) ? 128'(c[k] - cl) : 128'(cl - c[k]);
                sq += mag * mag;
            end
            a.hit = !bad && (sq < 128'(q.sr) * 128'(q.sr));
            return a;
        end
        for (int k = 0; k < 3; k++)
        begin
            d[k] = c[k] - o[k];
            mag = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
            sq += mag * mag;
        end
        // Bitwise integer square root.
        len = 0;
        for (int b = 34; b >= 0; b--)
        begin
            cand = len | (128'(1) << b);
            if (cand * cand <= sq)
                len = cand;
        end
        lenv = longint'(len);
        g = lenv - longint'(q.sr) - longint'(q.orad);
        a.hit = g < 0;
        if (g > 64'sh7fffffff)
            g = 64'sh7fffffff;
        if (g < -64'sh80000000)
            g = -64'sh80000000;
        a.gap = g[31:0];
        if (lenv > 0)
        begin
            a.dx = (d[0] < 0 ? -1 : 1) * int'(((128'(d[0] < 0 ? -d[0] : d[0])) << 30) / len);
            a.dy = (d[1] < 0 ? -1 : 1) * int'(((128'(d[1] < 0 ? -d[1] : d[1])) << 30) / len);
            a.dz = (d[2] < 0 ? -1 : 1) * int'(((128'(d[2] < 0 ? -d[2] : d[2])) << 30) / len);
            a.dvalid = 1'b1;
        end
        return a;
    endfunction

    function automatic int pick_coord(bit wide, int base);
        if (wide)
            return $urandom;
        return base + $urandom_range(0, 32'h60000) - 32'h30000;
    endfunction

    function automatic int pick_radius(bit wide);
        if (wide)
            return $urandom & 32'h7fffffff;
        return $urandom_range(0, 32'h40000);
    endfunction

    // Mostly nearby shapes so hits and misses both occur; some full range noise.
    function automatic query_t random_query();
        query_t q;
        bit     wide;
        int     bx, by, bz;
        wide = ($urandom_range(0, 9) == 0);
        bx = $urandom; by = $urandom; bz = $urandom;
        if (bx > 32'sh7f000000 || bx < -32'sh7f000000) bx = 0;
        if (by > 32'sh7f000000 || by < -32'sh7f000000) by = 0;
        if (bz > 32'sh7f000000 || bz < -32'sh7f000000) bz = 0;
        q.op = 1'($urandom_range(0, 1));
        q.sx = pick_coord(wide, bx); q.sy = pick_coord(wide, by); q.sz = pick_coord(wide, bz);
        q.ox = pick_coord(wide, bx); q.oy = pick_coord(wide, by); q.oz = pick_coord(wide, bz);
        q.sr = 31'(pick_radius(wide));
        q.orad = 31'(pick_radius(wide));
        if (wide || $urandom_range(0, 7) == 0)
        begin
            q.mx = pick_coord(wide, bx); q.my = pick_coord(wide, by);
            q.mz = pick_coord(wide, bz);
        end
        else
        begin
            q.mx = q.ox + $urandom_range(0, 32'h40000);
            q.my = q.oy + $urandom_range(0, 32'h40000);
            q.mz = q.oz + $urandom_range(0, 32'h40000);
        end
        return q;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(query_t q, answer_t a);
        int idle;
        idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= q.op;
        self_x       <= q.sx;  self_y <= q.sy;  self_z <= q.sz;
        self_radius  <= q.sr;
        other_x      <= q.ox;  other_y <= q.oy; other_z <= q.oz;
        box_max_x    <= q.mx;  box_max_y <= q.my; box_max_z <= q.mz;
        other_radius <= q.orad;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_answers.push_back(a);
    endtask

    // Result checking against the oldest pending answer.
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result word with no pending answer");
                errors++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit: expected %0d, got %0d", e.hit, hit);
                    errors++;
                end
                if (gap !== e.gap)
                begin
                    $error("gap: expected %0d, got %0d", e.gap, gap);
                    errors++;
                end
                if (dir_x !== e.dx)
                begin
                    $error("dir_x: expected %0d, got %0d", e.dx, dir_x);
                    errors++;
                end
                if (dir_y !== e.dy)
                begin
                    $error("dir_y: expected %0d, got %0d", e.dy, dir_y);
                    errors++;
                end
                if (dir_z !== e.dz)
                begin
                    $error("dir_z: expected %0d, got %0d", e.dz, dir_z);
                    errors++;
                end
                if (dir_valid !== e.dvalid)
                begin
                    $error("dir_valid: expected %0d, got %0d", e.dvalid, dir_valid);
                    errors++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        row_t r;
        int   waited;
        rst_n = 1'b0;
        start = 1'b0;
        op = sct_pkg::OP_BOX;
        self_x = 0; self_y = 0; self_z = 0; self_radius = 0;
        other_x = 0; other_y = 0; other_z = 0;
        box_max_x = 0; box_max_y = 0; box_max_z = 0; other_radius = 0;

        // Directed rows; typed answers only where they are obvious.
        // Center inside a box, nonzero radius.
        r.typed = 1;
        r.q = mk(sct_pkg::OP_BOX, 0, 0, 0, 1, -10, -10, -10, 10, 10, 10, 0);
        r.a = ans(1, 0, 0, 0, 0, 0); rows.push_back(r);
        // Invalid box with a min above its max.
        r.q = mk(sct_pkg::OP_BOX, 0, 0, 0, 100, 5, -10, -10, 4, 10, 10, 0);
        r.a = ans(0, 0, 0, 0, 0, 0); rows.push_back(r);
        // Zero radius inside a box never hits (strict compare).
        r.q = mk(sct_pkg::OP_BOX, 0, 0, 0, 0, -10, -10, -10, 10, 10, 10, 7);
        r.a = ans(0, 0, 0, 0, 0, 0); rows.push_back(r);
        // Coincident centers.
        r.q = mk(sct_pkg::OP_SPHERE, 3, 4, 5, 1, 3, 4, 5, 0, 0, 0, 2);
        r.a = ans(1, -3, 0, 0, 0, 0); rows.push_back(r);
        r.q = mk(sct_pkg::OP_SPHERE, 3, 4, 5, 0, 3, 4, 5, -1, -1, -1, 0);
        r.a = ans(0, 0, 0, 0, 0, 0); rows.push_back(r);
        // Coincident centers with largest radii: gap saturates low.
        r.q = mk(sct_pkg::OP_SPHERE, -1, -1, -1, 32'h7fffffff, -1, -1, -1, 0, 0, 0,
                 32'h7fffffff);
        r.a = ans(1, 32'h80000000, 0, 0, 0, 0); rows.push_back(r);
        // Unit offset on each axis.
        r.q = mk(sct_pkg::OP_SPHERE, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.a = ans(0, 32'h10000, 32'h40000000, 0, 0, 1); rows.push_back(r);
        r.q = mk(sct_pkg::OP_SPHERE, 0, -32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.a = ans(0, 32'h10000, 0, -32'h40000000, 0, 1); rows.push_back(r);
        r.q = mk(sct_pkg::OP_SPHERE, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0, 0, 0, 0);
        r.a = ans(0, 0, 0, 0, 32'h40000000, 1); rows.push_back(r);
        // Extremes and boundary cases, checked by the predictor.
        r.typed = 0;
        r.q = mk(sct_pkg::OP_SPHERE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
                 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_SPHERE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 32'h7fffffff);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_BOX, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_BOX, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 0);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_BOX, 100, 0, 0, 101, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_BOX, 100, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_SPHERE, 3, 4, 0, 2, 0, 0, 0, 0, 0, 0, 3);
        rows.push_back(r);
        r.q = mk(sct_pkg::OP_SPHERE, 3, 4, 0, 2, 0, 0, 0, 0, 0, 0, 4);
        rows.push_back(r);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].q, rows[i].typed ? rows[i].a : collide(rows[i].q));
        repeat (1200)
        begin
            r.q = random_query();
            send_word(r.q, collide(r.q));
        end
        start <= 1'b0;

        // Drain the pipeline.
        waited = 0;
        while (pending_answers.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/sct_pkg.sv
src/sct_front.sv
src/sct_sqrt.sv
src/sct_div.sv
src/sphere_collision_test.sv
dv/sphere_collision_test_tb.sv
